/* rtl/core/tlch_pkg.sv */
// ----------------------------------------------------------------------------
// tlch_pkg
// Shared types and geometry constants for the two-level cache hierarchy.
// ----------------------------------------------------------------------------
package tlch_pkg;

   localparam int WORD_BYTES   = 4;
   localparam int BLOCK_BYTES  = 64;
   localparam int L1_BYTES     = 4096;
   localparam int L2_BYTES     = 8192;
   localparam int MEMORY_BYTES = 65536;

   localparam int ADDR_W  = 16;
   localparam int DATA_W  = 32;
   localparam int COST_W  = 10;
   localparam int TIME_W  = 32;
   localparam int CSR_W   = 3;

   localparam int WORDS_PER_BLOCK = BLOCK_BYTES / WORD_BYTES;
   localparam int WORD_IDX_W      = $clog2(WORDS_PER_BLOCK);
   localparam int CNT_W           = WORD_IDX_W + 1;
   localparam int BYTE_W          = $clog2(WORD_BYTES);
   localparam int OFFS_W          = $clog2(BLOCK_BYTES);

   localparam int L1_LINES   = L1_BYTES / BLOCK_BYTES;
   localparam int L1_IDX_W   = $clog2(L1_LINES);
   localparam int L1_TAG_W   = ADDR_W - OFFS_W - L1_IDX_W;
   localparam int L1_WORDS   = L1_BYTES / WORD_BYTES;
   localparam int L1_WADDR_W = $clog2(L1_WORDS);

   localparam int L2_SETS    = L2_BYTES / BLOCK_BYTES / 2;
   localparam int L2_LINES   = 2 * L2_SETS;
   localparam int L2_IDX_W   = $clog2(L2_SETS);
   localparam int L2_LINE_W  = L2_IDX_W + 1;
   localparam int L2_TAG_W   = ADDR_W - OFFS_W - L2_IDX_W;
   localparam int L2_WORDS   = L2_BYTES / WORD_BYTES;
   localparam int L2_WADDR_W = $clog2(L2_WORDS);

   localparam int MEM_BLOCKS  = MEMORY_BYTES / BLOCK_BYTES;
   localparam int BLK_W       = $clog2(MEM_BLOCKS);
   localparam int MEM_WORDS   = MEMORY_BYTES / WORD_BYTES;
   localparam int MEM_WADDR_W = $clog2(MEM_WORDS);
   localparam int CLR_W       = MEM_WADDR_W + 1;

   typedef enum logic [1:0] {
      OP_READ        = 2'd0,
      OP_WRITE       = 2'd1,
      OP_CLEAR_TIME  = 2'd2,
      OP_INVALIDATE  = 2'd3
   } op_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_L1_READ_COST   = 3'd0,
      CSR_L1_WRITE_COST  = 3'd1,
      CSR_L2_READ_COST   = 3'd2,
      CSR_L2_WRITE_COST  = 3'd3,
      CSR_DRAM_READ_COST = 3'd4,
      CSR_DRAM_WRITE_COST = 3'd5
   } csr_type;

   typedef enum logic [1:0] {
      SEL_L1,
      SEL_L2,
      SEL_MEM,
      SEL_BUF
   } sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_L2_START,
      ST_L2_TAG,
      ST_L2_FILL,
      ST_L2_XFER,
      ST_L2_STAMP,
      ST_L1_FILL,
      ST_WORD,
      ST_COPY
   } state_type;

endpackage

/* rtl/core/tlch_ram.sv */
// ----------------------------------------------------------------------------
// tlch_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tlch_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/two_level_cache_hierarchy_top.sv */
// ----------------------------------------------------------------------------
// two_level_cache_hierarchy_top
// Direct-mapped write-back L1 and two-way write-back L2 in front of a word
// memory, with a running access-time total.
// ----------------------------------------------------------------------------
// One request at a time. An L1 hit is answered from the lookup state. An
// L1 miss that hits in L2 moves blocks through the copy loop, and every
// block move runs through the one-word-per-cycle RAM ports. An L2 miss
// adds the fill from memory, plus a write-back when the replaced way is
// dirty, and a dirty L1 victim adds a second L2 access plus its own miss
// moves. Clear-time and invalidate are answered from the lookup state.
// After reset all 16384 words of backing memory are zeroed one word per
// cycle while requests are held off; cost registers may be written meanwhile.
module two_level_cache_hierarchy_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_op,
   input  logic [tlch_pkg::ADDR_W-1:0]    req_address,
   input  logic [tlch_pkg::DATA_W-1:0]    req_write_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [tlch_pkg::DATA_W-1:0]    rsp_read_data,
   output logic [tlch_pkg::TIME_W-1:0]    rsp_elapsed_time,
   output logic                           rsp_l1_hit,
   output logic                           rsp_l2_hit,
   input  logic                           csr_write_enable,
   input  logic [tlch_pkg::CSR_W-1:0]     csr_index,
   input  logic [tlch_pkg::COST_W-1:0]    csr_write_data
);
   import tlch_pkg::*;

   state_type state_ff, state_in, ret_ff, ret_in;
   op_type    op_ff, op_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [DATA_W-1:0] wdata_ff, wdata_in;
   logic h2_ff, h2_in, vic_dirty_ff, vic_dirty_in, acc_wr_ff, acc_wr_in, way_ff, way_in;
   logic [L1_TAG_W-1:0]   vic_tag_ff, vic_tag_in;
   logic [BLK_W-1:0]      acc_blk_ff, acc_blk_in;
   logic [2*L2_TAG_W-1:0] tags_ff, tags_in;
   logic [2*TIME_W-1:0]   stamps_ff, stamps_in;

   sel_type cp_src_ff, cp_src_in, cp_dst_ff, cp_dst_in;
   logic [BLK_W-1:0]      cp_sblk_ff, cp_sblk_in, cp_dblk_ff, cp_dblk_in;
   logic [CNT_W-1:0]      cp_cnt_ff, cp_cnt_in;
   logic                  cp_vld_ff, cp_vld_in;
   logic [WORD_IDX_W-1:0] cp_idx_ff, cp_idx_in;
   logic [DATA_W-1:0]     buf_ff [WORDS_PER_BLOCK];
   logic [DATA_W-1:0]     buf_in [WORDS_PER_BLOCK];
   logic [DATA_W-1:0]     word_ff, word_in;

   logic [TIME_W-1:0] time_ff, time_in;
   logic [COST_W-1:0] l1r_ff, l1w_ff, l2r_ff, l2w_ff, drr_ff, drw_ff;

   logic [L1_LINES-1:0] l1_v_ff, l1_v_in, l1_d_ff, l1_d_in;
   logic [L2_LINES-1:0] l2_v_ff, l2_v_in, l2_d_ff, l2_d_in, l2_ok_ff, l2_ok_in;

   logic              rsp_valid_ff, rsp_valid_in, rsp_h1_ff, rsp_h1_in, rsp_h2_ff, rsp_h2_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [TIME_W-1:0] rsp_time_ff, rsp_time_in;

   logic [CLR_W-1:0] clr_ff, clr_in;
   logic clearing;

   // memory ports
   logic                  l1d_we, l2d_we, mem_we, l1t_we, l2t_we, l2s_we;
   logic [L1_WADDR_W-1:0] l1d_wa, l1d_ra;
   logic [DATA_W-1:0]     l1d_wd, l1d_rd, l2d_rd, mem_wd, mem_rd, cp_data;
   logic [L2_WADDR_W-1:0] l2d_wa, l2d_ra;
   logic [MEM_WADDR_W-1:0] mem_wa, mem_ra;
   logic [L1_IDX_W-1:0]   l1t_ra;
   logic [L1_TAG_W-1:0]   l1t_rd;
   logic [2*L2_TAG_W-1:0] l2t_wd, l2t_rd;
   logic [2*TIME_W-1:0]   l2s_wd, l2s_rd;

   logic [L1_IDX_W-1:0]   line;
   logic [L1_TAG_W-1:0]   tag;
   logic [WORD_IDX_W-1:0] widx;
   logic [L2_IDX_W-1:0]   aset;
   logic [L2_TAG_W-1:0]   atag, tg0, tg1;
   logic [TIME_W-1:0]     st0, st1;
   logic [L2_LINE_W-1:0]  l2line, l2i0, l2i1;
   logic hit0, hit1, l2hit, sel_way, l1hit, issue;

   assign line     = addr_ff[OFFS_W +: L1_IDX_W];
   assign tag      = addr_ff[OFFS_W+L1_IDX_W +: L1_TAG_W];
   assign widx     = addr_ff[BYTE_W +: WORD_IDX_W];
   assign aset     = acc_blk_ff[L2_IDX_W-1:0];
   assign atag     = acc_blk_ff[L2_IDX_W +: L2_TAG_W];
   assign l2i0     = {aset, 1'b0};
   assign l2i1     = {aset, 1'b1};
   assign tg0      = l2t_rd[L2_TAG_W-1:0];
   assign tg1      = l2t_rd[2*L2_TAG_W-1:L2_TAG_W];
   assign st0      = l2_ok_ff[l2i0] ? l2s_rd[TIME_W-1:0] : '0;
   assign st1      = l2_ok_ff[l2i1] ? l2s_rd[2*TIME_W-1:TIME_W] : '0;
   assign hit0     = l2_v_ff[l2i0] && (tg0 == atag);
   assign hit1     = l2_v_ff[l2i1] && (tg1 == atag);
   assign l2hit    = hit0 || hit1;
   assign sel_way  = hit0 ? 1'b0 : (hit1 ? 1'b1 : ((st0 < st1) ? 1'b0 : 1'b1));
   assign l2line   = {aset, way_ff};
   assign l1hit    = l1_v_ff[line] && (l1t_rd == tag);
   assign issue    = !cp_cnt_ff[WORD_IDX_W];
   assign clearing = clr_ff < CLR_W'(MEM_WORDS);

   assign l1d_ra = (state_ff == ST_IDLE)
      ? {req_address[OFFS_W +: L1_IDX_W], req_address[BYTE_W +: WORD_IDX_W]}
      : {cp_sblk_ff[L1_IDX_W-1:0], cp_cnt_ff[WORD_IDX_W-1:0]};
   assign l1t_ra = req_address[OFFS_W +: L1_IDX_W];
   assign l2d_ra = {cp_sblk_ff[L2_LINE_W-1:0], cp_cnt_ff[WORD_IDX_W-1:0]};
   assign mem_ra = {cp_sblk_ff, cp_cnt_ff[WORD_IDX_W-1:0]};
   assign l2d_wa = {cp_dblk_ff[L2_LINE_W-1:0], cp_idx_ff};

   always_comb begin
      case (cp_src_ff)
         SEL_L1:  cp_data = l1d_rd;
         SEL_L2:  cp_data = l2d_rd;
         SEL_MEM: cp_data = mem_rd;
         default: cp_data = buf_ff[cp_idx_ff];
      endcase
   end

   always_comb begin
      state_in = state_ff;   ret_in = ret_ff;
      op_in = op_ff;         addr_in = addr_ff;     wdata_in = wdata_ff;
      h2_in = h2_ff;         vic_dirty_in = vic_dirty_ff;  vic_tag_in = vic_tag_ff;
      acc_wr_in = acc_wr_ff; acc_blk_in = acc_blk_ff; way_in = way_ff;
      tags_in = tags_ff;     stamps_in = stamps_ff;
      cp_src_in = cp_src_ff; cp_dst_in = cp_dst_ff;
      cp_sblk_in = cp_sblk_ff; cp_dblk_in = cp_dblk_ff;
      cp_cnt_in = cp_cnt_ff; cp_vld_in = 1'b0; cp_idx_in = cp_cnt_ff[WORD_IDX_W-1:0];
      buf_in = buf_ff;       word_in = word_ff;
      time_in = time_ff;
      l1_v_in = l1_v_ff; l1_d_in = l1_d_ff;
      l2_v_in = l2_v_ff; l2_d_in = l2_d_ff; l2_ok_in = l2_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff; rsp_time_in = rsp_time_ff;
      rsp_h1_in = rsp_h1_ff; rsp_h2_in = rsp_h2_ff;
      clr_in = clr_ff;
      req_ready = 1'b0;
      l1d_we = 1'b0; l1d_wa = {line, widx}; l1d_wd = wdata_ff;
      l2d_we = 1'b0;
      mem_we = 1'b0; mem_wa = {cp_dblk_ff, cp_idx_ff}; mem_wd = cp_data;
      l1t_we = 1'b0;
      l2t_we = 1'b0;
      l2t_wd = way_ff ? {atag, tags_ff[L2_TAG_W-1:0]}
                      : {tags_ff[2*L2_TAG_W-1:L2_TAG_W], atag};
      l2s_we = 1'b0;
      l2s_wd = way_ff ? {time_ff, stamps_ff[TIME_W-1:0]}
                      : {stamps_ff[2*TIME_W-1:TIME_W], time_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (clearing) begin
               mem_we = 1'b1;
               mem_wa = clr_ff[MEM_WADDR_W-1:0];
               mem_wd = '0;
               clr_in = clr_ff + CLR_W'(1);
            end else begin
               req_ready = !rsp_valid_ff || rsp_ready;
               if (req_valid && req_ready) begin
                  op_in    = op_type'(req_op);
                  addr_in  = req_address;
                  wdata_in = req_write_data;
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            state_in = ST_IDLE;
            rsp_data_in = '0;
            rsp_h1_in = 1'b0;
            rsp_h2_in = 1'b0;
            case (op_ff)
               OP_CLEAR_TIME: begin
                  time_in = '0;
                  rsp_valid_in = 1'b1;
               end
               OP_INVALIDATE: begin
                  l1_v_in = '0; l1_d_in = '0;
                  l2_v_in = '0; l2_d_in = '0; l2_ok_in = '0;
                  rsp_valid_in = 1'b1;
               end
               default: begin
                  if (l1hit) begin
                     rsp_valid_in = 1'b1;
                     rsp_h1_in = 1'b1;
                     if (op_ff == OP_READ) begin
                        rsp_data_in = l1d_rd;
                        time_in = time_ff + TIME_W'(l1r_ff);
                     end else begin
                        l1d_we = 1'b1;
                        l1_d_in[line] = 1'b1;
                        time_in = time_ff + TIME_W'(l1w_ff);
                     end
                  end else begin
                     vic_dirty_in = l1_v_ff[line] && l1_d_ff[line];
                     vic_tag_in = l1t_rd;
                     acc_wr_in = 1'b0;
                     acc_blk_in = addr_ff[OFFS_W +: BLK_W];
                     state_in = ST_L2_START;
                  end
               end
            endcase
         end
         ST_L2_START: begin
            state_in = ST_L2_TAG;
         end
         ST_L2_TAG: begin
            way_in = sel_way;
            tags_in = l2t_rd;
            stamps_in = {st1, st0};
            if (!acc_wr_ff) begin
               h2_in = l2hit;
            end
            if (l2hit) begin
               state_in = ST_L2_XFER;
            end else if (l2_v_ff[{aset, sel_way}] && l2_d_ff[{aset, sel_way}]) begin
               cp_src_in = SEL_L2;
               cp_dst_in = SEL_MEM;
               cp_sblk_in = BLK_W'({aset, sel_way});
               cp_dblk_in = {sel_way ? tg1 : tg0, aset};
               cp_cnt_in = '0;
               time_in = time_ff + TIME_W'(drw_ff);
               ret_in = ST_L2_FILL;
               state_in = ST_COPY;
            end else begin
               state_in = ST_L2_FILL;
            end
         end
         ST_L2_FILL: begin
            l2t_we = 1'b1;
            l2_v_in[l2line] = 1'b1;
            l2_d_in[l2line] = 1'b0;
            cp_src_in = SEL_MEM;
            cp_dst_in = SEL_L2;
            cp_sblk_in = acc_blk_ff;
            cp_dblk_in = BLK_W'(l2line);
            cp_cnt_in = '0;
            time_in = time_ff + TIME_W'(drr_ff);
            ret_in = ST_L2_XFER;
            state_in = ST_COPY;
         end
         ST_L2_XFER: begin
            cp_cnt_in = '0;
            ret_in = ST_L2_STAMP;
            state_in = ST_COPY;
            if (acc_wr_ff) begin
               cp_src_in = SEL_L1;
               cp_dst_in = SEL_L2;
               cp_sblk_in = BLK_W'(line);
               cp_dblk_in = BLK_W'(l2line);
               l2_d_in[l2line] = 1'b1;
               time_in = time_ff + TIME_W'(l2w_ff);
            end else begin
               cp_src_in = SEL_L2;
               cp_dst_in = SEL_BUF;
               cp_sblk_in = BLK_W'(l2line);
               time_in = time_ff + TIME_W'(l2r_ff);
            end
         end
         ST_L2_STAMP: begin
            l2s_we = 1'b1;
            l2_ok_in[l2line] = 1'b1;
            if (!acc_wr_ff && vic_dirty_ff) begin
               acc_wr_in = 1'b1;
               acc_blk_in = {vic_tag_ff, line};
               state_in = ST_L2_START;
            end else begin
               state_in = ST_L1_FILL;
            end
         end
         ST_L1_FILL: begin
            l1t_we = 1'b1;
            l1_v_in[line] = 1'b1;
            l1_d_in[line] = 1'b0;
            cp_src_in = SEL_BUF;
            cp_dst_in = SEL_L1;
            cp_dblk_in = BLK_W'(line);
            cp_cnt_in = '0;
            ret_in = ST_WORD;
            state_in = ST_COPY;
         end
         ST_WORD: begin
            state_in = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_h1_in = 1'b0;
            rsp_h2_in = h2_ff;
            if (op_ff == OP_READ) begin
               rsp_data_in = word_ff;
               time_in = time_ff + TIME_W'(l1r_ff);
            end else begin
               rsp_data_in = '0;
               l1d_we = 1'b1;
               l1_d_in[line] = 1'b1;
               time_in = time_ff + TIME_W'(l1w_ff);
            end
         end
         ST_COPY: begin
            if (issue) begin
               cp_cnt_in = cp_cnt_ff + CNT_W'(1);
               cp_vld_in = 1'b1;
            end
            if (cp_vld_ff) begin
               case (cp_dst_ff)
                  SEL_L1: begin
                     l1d_we = 1'b1;
                     l1d_wa = {cp_dblk_ff[L1_IDX_W-1:0], cp_idx_ff};
                     l1d_wd = cp_data;
                     if (cp_idx_ff == widx) begin
                        word_in = cp_data;
                     end
                  end
                  SEL_L2:  l2d_we = 1'b1;
                  SEL_MEM: mem_we = 1'b1;
                  default: buf_in[cp_idx_ff] = cp_data;
               endcase
               if (cp_idx_ff == WORD_IDX_W'(WORDS_PER_BLOCK - 1)) begin
                  state_in = ret_ff;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_time_in = rsp_valid_in && !(rsp_valid_ff && !rsp_ready) ? time_in : rsp_time_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         cp_cnt_ff    <= '0;
         cp_vld_ff    <= 1'b0;
         time_ff      <= '0;
         l1_v_ff      <= '0;
         l1_d_ff      <= '0;
         l2_v_ff      <= '0;
         l2_d_ff      <= '0;
         l2_ok_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
         l1r_ff <= COST_W'(1);
         l1w_ff <= COST_W'(1);
         l2r_ff <= COST_W'(10);
         l2w_ff <= COST_W'(10);
         drr_ff <= COST_W'(100);
         drw_ff <= COST_W'(50);
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         cp_cnt_ff    <= cp_cnt_in;
         cp_vld_ff    <= cp_vld_in;
         time_ff      <= time_in;
         l1_v_ff      <= l1_v_in;
         l1_d_ff      <= l1_d_in;
         l2_v_ff      <= l2_v_in;
         l2_d_ff      <= l2_d_in;
         l2_ok_ff     <= l2_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_ff       <= clr_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_L1_READ_COST:    l1r_ff <= csr_write_data;
               CSR_L1_WRITE_COST:   l1w_ff <= csr_write_data;
               CSR_L2_READ_COST:    l2r_ff <= csr_write_data;
               CSR_L2_WRITE_COST:   l2w_ff <= csr_write_data;
               CSR_DRAM_READ_COST:  drr_ff <= csr_write_data;
               CSR_DRAM_WRITE_COST: drw_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      addr_ff      <= addr_in;
      wdata_ff     <= wdata_in;
      h2_ff        <= h2_in;
      vic_dirty_ff <= vic_dirty_in;
      vic_tag_ff   <= vic_tag_in;
      acc_wr_ff    <= acc_wr_in;
      acc_blk_ff   <= acc_blk_in;
      way_ff       <= way_in;
      tags_ff      <= tags_in;
      stamps_ff    <= stamps_in;
      cp_src_ff    <= cp_src_in;
      cp_dst_ff    <= cp_dst_in;
      cp_sblk_ff   <= cp_sblk_in;
      cp_dblk_ff   <= cp_dblk_in;
      cp_idx_ff    <= cp_idx_in;
      buf_ff       <= buf_in;
      word_ff      <= word_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_time_ff  <= rsp_time_in;
      rsp_h1_ff    <= rsp_h1_in;
      rsp_h2_ff    <= rsp_h2_in;
   end

   tlch_ram #(.WIDTH(DATA_W), .DEPTH(L1_WORDS)) u_l1_data (
      .clock(clock), .wr_en(l1d_we), .wr_addr(l1d_wa), .wr_data(l1d_wd),
      .rd_addr(l1d_ra), .rd_data(l1d_rd)
   );

   tlch_ram #(.WIDTH(L1_TAG_W), .DEPTH(L1_LINES)) u_l1_tag (
      .clock(clock), .wr_en(l1t_we), .wr_addr(line), .wr_data(tag),
      .rd_addr(l1t_ra), .rd_data(l1t_rd)
   );

   tlch_ram #(.WIDTH(DATA_W), .DEPTH(L2_WORDS)) u_l2_data (
      .clock(clock), .wr_en(l2d_we), .wr_addr(l2d_wa), .wr_data(cp_data),
      .rd_addr(l2d_ra), .rd_data(l2d_rd)
   );

   tlch_ram #(.WIDTH(2*L2_TAG_W), .DEPTH(L2_SETS)) u_l2_tag (
      .clock(clock), .wr_en(l2t_we), .wr_addr(aset), .wr_data(l2t_wd),
      .rd_addr(aset), .rd_data(l2t_rd)
   );

   tlch_ram #(.WIDTH(2*TIME_W), .DEPTH(L2_SETS)) u_l2_stamp (
      .clock(clock), .wr_en(l2s_we), .wr_addr(aset), .wr_data(l2s_wd),
      .rd_addr(aset), .rd_data(l2s_rd)
   );

   tlch_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_main_mem (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_wa), .wr_data(mem_wd),
      .rd_addr(mem_ra), .rd_data(mem_rd)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_data_ff;
   assign rsp_elapsed_time = rsp_time_ff;
   assign rsp_l1_hit       = rsp_h1_ff;
   assign rsp_l2_hit       = rsp_h2_ff;

endmodule

/* rtl/core/tlch_checker.sv */
// ----------------------------------------------------------------------------
// tlch_checker
// Port-level checks for the cache hierarchy, bound to the top level.
// ----------------------------------------------------------------------------
module tlch_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [tlch_pkg::DATA_W-1:0] rsp_read_data,
   input logic                        rsp_l1_hit,
   input logic                        rsp_l2_hit
);
   import tlch_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
      else $error("result beat dropped or changed while stalled");

   a_accept_slot: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid || rsp_ready)
      else $error("request taken while result slot is blocked");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid && !req_ready)
      else $error("result or new request too soon after accept");

   a_hit_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_l1_hit && rsp_l2_hit))
      else $error("both hit flags set");

endmodule

bind two_level_cache_hierarchy_top tlch_checker u_tlch_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_read_data(rsp_read_data),
   .rsp_l1_hit(rsp_l1_hit), .rsp_l2_hit(rsp_l2_hit)
);
